>>> rtl/lmfe_pkg.sv
package lmfe_pkg;

    typedef logic [2:0] req_t;
    typedef logic [2:0] tgt_t;
    typedef logic [1:0] alu_op_t;

    localparam req_t REQ_SET      = 3'd0;
    localparam req_t REQ_ADD      = 3'd1;
    localparam req_t REQ_INVERT   = 3'd2;
    localparam req_t REQ_READ_WRK = 3'd3;
    localparam req_t REQ_SHOW     = 3'd4;
    localparam req_t REQ_READ_DSP = 3'd5;

    localparam tgt_t TGT_PIXEL = 3'd0;
    localparam tgt_t TGT_ROW   = 3'd1;
    localparam tgt_t TGT_COL   = 3'd2;
    localparam tgt_t TGT_FRAME = 3'd3;
    localparam tgt_t TGT_STRIP = 3'd4;

    localparam alu_op_t ALU_SET    = 2'd0;
    localparam alu_op_t ALU_ADD    = 2'd1;
    localparam alu_op_t ALU_INVERT = 2'd2;

    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    localparam int PIX_W  = 24;
    localparam int CHAN_W = 8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_DIVIDE,
        ST_RD,
        ST_WR,
        ST_DONE
    } state_t;

endpackage

>>> rtl/lmfe_pixel_alu.sv
module lmfe_pixel_alu (
    input  lmfe_pkg::alu_op_t              op,
    input  logic [lmfe_pkg::PIX_W-1:0]     old_pix,
    input  logic [lmfe_pkg::PIX_W-1:0]     val_pix,
    output logic [lmfe_pkg::PIX_W-1:0]     new_pix
);

    always_comb
    begin
        logic [lmfe_pkg::CHAN_W:0]   sum;
        logic [lmfe_pkg::CHAN_W-1:0] o;
        logic [lmfe_pkg::CHAN_W-1:0] v;
        new_pix = '0;
        for (int k = 0; k < 3; k++)
        begin
            o   = old_pix[k*lmfe_pkg::CHAN_W +: lmfe_pkg::CHAN_W];
            v   = val_pix[k*lmfe_pkg::CHAN_W +: lmfe_pkg::CHAN_W];
            sum = {1'b0, o} + {1'b0, v};
            case (op)
                lmfe_pkg::ALU_SET:
                    new_pix[k*lmfe_pkg::CHAN_W +: lmfe_pkg::CHAN_W] = v;
                lmfe_pkg::ALU_ADD:
                    new_pix[k*lmfe_pkg::CHAN_W +: lmfe_pkg::CHAN_W] =
                        sum[lmfe_pkg::CHAN_W] ? '1 : sum[lmfe_pkg::CHAN_W-1:0];
                default:
                    new_pix[k*lmfe_pkg::CHAN_W +: lmfe_pkg::CHAN_W] = ~o;
            endcase
        end
    end

endmodule

>>> rtl/lmfe_frame_mem.sv
module lmfe_frame_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [lmfe_pkg::PIX_W-1:0]   wdata,
    input  logic [AW-1:0]                raddr,
    output logic [lmfe_pkg::PIX_W-1:0]   rdata
);

    logic [lmfe_pkg::PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/led_matrix_frame_engine_core.sv
// each request is decoded, then every pixel it touches is read and written
// back in turn; strip and read requests first map the index, stepping a row
// at a time; whole frame and show pass every pixel through the single
// read-modify-write port pair of the frame memories; one word at a time
// after reset both frames are cleared, one entry a cycle, for all
// MAX_ROWS * MAX_COLS entries while no word is accepted
module led_matrix_frame_engine_core #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [2:0]  target,
    input  logic [4:0]  row,
    input  logic [4:0]  col,
    input  logic [5:0]  span_start,
    input  logic [5:0]  span_end,
    input  logic [9:0]  strip_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [7:0]  read_red,
    output logic [7:0]  read_green,
    output logic [7:0]  read_blue,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);

    lmfe_pkg::state_t state_reg, state_next;

    logic [5:0]  cols_reg, rows_reg;
    logic [2:0]  req_reg, tgt_reg;
    logic [4:0]  row_reg, col_reg;
    logic [5:0]  s_reg, e_reg;
    logic [9:0]  strip_reg;
    logic [9:0]  rem_reg, rem_next;
    logic [23:0] val_reg;
    logic [RCW-1:0] cur_r_reg, cur_r_next, r_end_reg, r_end_next;
    logic [CCW-1:0] cur_c_reg, cur_c_next, c_start_reg, c_start_next, c_end_reg, c_end_next;
    logic [RCW-1:0] q_reg, q_next;
    logic        err_reg, err_next;
    logic [23:0] pix_reg, pix_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic        out_valid_reg, out_valid_next;
    logic        status_reg, status_next;
    logic [23:0] out_pix_reg, out_pix_next;

    logic [RCW-1:0] rows_eff;
    logic [CCW-1:0] cols_eff;

    logic          wrk_we, dsp_we;
    logic [AW-1:0] waddr, raddr;
    logic [23:0]   wrk_wdata, dsp_wdata, wrk_rdata, dsp_rdata, alu_pix;

    logic [5:0]  lo, hi;
    logic        accept;

    function automatic logic [AW-1:0] pix_addr(input logic [RCW-1:0] r,
                                               input logic [CCW-1:0] c);
        pix_addr = AW'(int'(r) * MAX_COLS + int'(c));
    endfunction

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != lmfe_pkg::ST_IDLE);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == lmfe_pkg::REG_ROWS) ? {26'd0, rows_reg} : {26'd0, cols_reg};

    assign cols_eff = (cols_reg == 6'd0) ? CCW'(1) :
                      (int'(cols_reg) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_reg);
    assign rows_eff = (rows_reg == 6'd0) ? RCW'(1) :
                      (int'(rows_reg) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_reg);

    assign lo = (s_reg > e_reg) ? e_reg : s_reg;
    assign hi = (s_reg > e_reg) ? s_reg : e_reg;

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_red   = out_pix_reg[23:16];
    assign read_green = out_pix_reg[15:8];
    assign read_blue  = out_pix_reg[7:0];

    lmfe_pixel_alu u_alu (
        .op      (lmfe_pkg::alu_op_t'(req_reg[1:0])),
        .old_pix (wrk_rdata),
        .val_pix (val_reg),
        .new_pix (alu_pix)
    );

    lmfe_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_working (
        .clk   (clk),
        .we    (wrk_we),
        .waddr (waddr),
        .wdata (wrk_wdata),
        .raddr (raddr),
        .rdata (wrk_rdata)
    );

    lmfe_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_display (
        .clk   (clk),
        .we    (dsp_we),
        .waddr (waddr),
        .wdata (dsp_wdata),
        .raddr (raddr),
        .rdata (dsp_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmfe_pkg::ST_CLEAR:
            begin
                if (int'(clr_reg) == DEPTH - 1)
                    state_next = lmfe_pkg::ST_IDLE;
            end
            lmfe_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = lmfe_pkg::ST_DECODE;
            end
            lmfe_pkg::ST_DECODE:
            begin
                state_next = lmfe_pkg::ST_DONE;
                case (req_reg) inside
                    lmfe_pkg::REQ_SET, lmfe_pkg::REQ_ADD, lmfe_pkg::REQ_INVERT:
                    begin
                        case (tgt_reg)
                            lmfe_pkg::TGT_PIXEL:
                                if (int'(row_reg) < int'(rows_eff) && int'(col_reg) < int'(cols_eff))
                                    state_next = lmfe_pkg::ST_RD;
                            lmfe_pkg::TGT_ROW:
                                if (int'(row_reg) < int'(rows_eff) && int'(lo) <= int'(cols_eff)
                                    && int'(lo) < int'(hi) && int'(lo) < int'(cols_eff))
                                    state_next = lmfe_pkg::ST_RD;
                            lmfe_pkg::TGT_COL:
                                if (int'(col_reg) < int'(cols_eff) && int'(lo) <= int'(rows_eff)
                                    && int'(lo) < int'(hi) && int'(lo) < int'(rows_eff))
                                    state_next = lmfe_pkg::ST_RD;
                            lmfe_pkg::TGT_FRAME:
                                state_next = lmfe_pkg::ST_RD;
                            lmfe_pkg::TGT_STRIP:
                                state_next = lmfe_pkg::ST_DIVIDE;
                            default:
                                state_next = lmfe_pkg::ST_DONE;
                        endcase
                    end
                    lmfe_pkg::REQ_READ_WRK, lmfe_pkg::REQ_READ_DSP:
                        state_next = lmfe_pkg::ST_DIVIDE;
                    lmfe_pkg::REQ_SHOW:
                        state_next = lmfe_pkg::ST_RD;
                    default:
                        state_next = lmfe_pkg::ST_DONE;
                endcase
            end
            lmfe_pkg::ST_DIVIDE:
            begin
                if (q_reg == rows_eff)
                    state_next = lmfe_pkg::ST_DONE;
                else if (int'(rem_reg) < int'(cols_eff))
                    state_next = lmfe_pkg::ST_RD;
            end
            lmfe_pkg::ST_RD:
                state_next = lmfe_pkg::ST_WR;
            lmfe_pkg::ST_WR:
            begin
                if (!(int'(cur_c_reg) + 1 < int'(c_end_reg)) &&
                    !(int'(cur_r_reg) + 1 < int'(r_end_reg)))
                    state_next = lmfe_pkg::ST_DONE;
                else
                    state_next = lmfe_pkg::ST_RD;
            end
            lmfe_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = lmfe_pkg::ST_IDLE;
            end
            default:
                state_next = lmfe_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cur_r_next     = cur_r_reg;
        cur_c_next     = cur_c_reg;
        r_end_next     = r_end_reg;
        c_start_next   = c_start_reg;
        c_end_next     = c_end_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        err_next       = err_reg;
        pix_next       = pix_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        out_pix_next   = out_pix_reg;
        wrk_we         = 1'b0;
        dsp_we         = 1'b0;
        waddr          = pix_addr(cur_r_reg, cur_c_reg);
        raddr          = pix_addr(cur_r_reg, cur_c_reg);
        wrk_wdata      = alu_pix;
        dsp_wdata      = wrk_rdata;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            lmfe_pkg::ST_CLEAR:
            begin
                wrk_we    = 1'b1;
                dsp_we    = 1'b1;
                waddr     = clr_reg;
                wrk_wdata = '0;
                dsp_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            lmfe_pkg::ST_DECODE:
            begin
                err_next     = 1'b1;
                pix_next     = '0;
                q_next       = '0;
                rem_next     = strip_reg;
                cur_r_next   = '0;
                cur_c_next   = '0;
                c_start_next = '0;
                r_end_next   = rows_eff;
                c_end_next   = cols_eff;
                case (req_reg) inside
                    lmfe_pkg::REQ_SET, lmfe_pkg::REQ_ADD, lmfe_pkg::REQ_INVERT:
                    begin
                        case (tgt_reg)
                            lmfe_pkg::TGT_PIXEL:
                            begin
                                err_next     = !(int'(row_reg) < int'(rows_eff) &&
                                                 int'(col_reg) < int'(cols_eff));
                                cur_r_next   = RCW'(row_reg);
                                cur_c_next   = CCW'(col_reg);
                                c_start_next = CCW'(col_reg);
                                r_end_next   = RCW'(row_reg) + 1'b1;
                                c_end_next   = CCW'(col_reg) + 1'b1;
                            end
                            lmfe_pkg::TGT_ROW:
                            begin
                                err_next     = !(int'(row_reg) < int'(rows_eff) &&
                                                 int'(lo) <= int'(cols_eff));
                                cur_r_next   = RCW'(row_reg);
                                cur_c_next   = CCW'(lo);
                                c_start_next = CCW'(lo);
                                r_end_next   = RCW'(row_reg) + 1'b1;
                                c_end_next   = (int'(hi) > int'(cols_eff)) ? cols_eff : CCW'(hi);
                            end
                            lmfe_pkg::TGT_COL:
                            begin
                                err_next     = !(int'(col_reg) < int'(cols_eff) &&
                                                 int'(lo) <= int'(rows_eff));
                                cur_r_next   = RCW'(lo);
                                cur_c_next   = CCW'(col_reg);
                                c_start_next = CCW'(col_reg);
                                r_end_next   = (int'(hi) > int'(rows_eff)) ? rows_eff : RCW'(hi);
                                c_end_next   = CCW'(col_reg) + 1'b1;
                            end
                            lmfe_pkg::TGT_FRAME:
                                err_next = 1'b0;
                            lmfe_pkg::TGT_STRIP:
                                err_next = 1'b0;
                            default:
                                err_next = 1'b1;
                        endcase
                    end
                    lmfe_pkg::REQ_READ_WRK, lmfe_pkg::REQ_READ_DSP, lmfe_pkg::REQ_SHOW:
                        err_next = 1'b0;
                    default:
                        err_next = 1'b1;
                endcase
            end
            lmfe_pkg::ST_DIVIDE:
            begin
                if (q_reg == rows_eff)
                begin
                    err_next = 1'b1;
                end
                else if (int'(rem_reg) < int'(cols_eff))
                begin
                    cur_r_next   = q_reg;
                    cur_c_next   = q_reg[0] ? CCW'(cols_eff - 1'b1 - CCW'(rem_reg))
                                            : CCW'(rem_reg);
                    c_start_next = '0;
                    r_end_next   = q_reg + 1'b1;
                    c_end_next   = '0;
                end
                else
                begin
                    rem_next = rem_reg - 10'(cols_eff);
                    q_next   = q_reg + 1'b1;
                end
            end
            lmfe_pkg::ST_WR:
            begin
                case (req_reg) inside
                    lmfe_pkg::REQ_SET, lmfe_pkg::REQ_ADD, lmfe_pkg::REQ_INVERT:
                        wrk_we = 1'b1;
                    lmfe_pkg::REQ_SHOW:
                        dsp_we = 1'b1;
                    lmfe_pkg::REQ_READ_WRK:
                        pix_next = wrk_rdata;
                    lmfe_pkg::REQ_READ_DSP:
                        pix_next = dsp_rdata;
                    default:
                        pix_next = pix_reg;
                endcase
                if (int'(cur_c_reg) + 1 < int'(c_end_reg))
                begin
                    cur_c_next = cur_c_reg + 1'b1;
                end
                else if (int'(cur_r_reg) + 1 < int'(r_end_reg))
                begin
                    cur_r_next = cur_r_reg + 1'b1;
                    cur_c_next = c_start_reg;
                end
            end
            lmfe_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = err_reg;
                    out_pix_next   = err_reg ? '0 : pix_reg;
                end
            end
            default:
                clr_next = clr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lmfe_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            cols_reg      <= 6'd12;
            rows_reg      <= 6'd12;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == lmfe_pkg::REG_ROWS)
                    rows_reg <= pwdata[5:0];
                else
                    cols_reg <= pwdata[5:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            tgt_reg   <= target;
            row_reg   <= row;
            col_reg   <= col;
            s_reg     <= span_start;
            e_reg     <= span_end;
            strip_reg <= strip_index;
            val_reg   <= {red, green, blue};
        end
        cur_r_reg   <= cur_r_next;
        cur_c_reg   <= cur_c_next;
        r_end_reg   <= r_end_next;
        c_start_reg <= c_start_next;
        c_end_reg   <= c_end_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        err_reg     <= err_next;
        pix_reg     <= pix_next;
        status_reg  <= status_next;
        out_pix_reg <= out_pix_next;
    end

endmodule
